// ----- design/kcrl_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package kcrl_pkg;

	localparam int ENTRIES  = 16;
	localparam int KEY_BITS = 64;
	localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	typedef enum logic [1:0] {
		OUT_BYPASS    = 2'd0,
		OUT_LIMITED   = 2'd1,
		OUT_REFRESHED = 2'd2,
		OUT_INSERTED  = 2'd3
	} outcome_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic [63:0] key_tag;
		logic        key_present;
		logic [31:0] cooldown;
		logic [63:0] now_time;
	} in_t;

	typedef struct packed {
		logic       limited;
		logic [1:0] outcome;
	} out_t;

	typedef struct packed {
		logic [KEY_BITS-1:0] key;
		logic [31:0]         cool;
		logic [63:0]         now;
	} req_t;

	typedef struct packed {
		logic active;
		logic hit;
		logic lim;
	} link_t;

	typedef struct packed {
		logic             ins;
		logic [IDX_W-1:0] slot;
	} wr_t;

endpackage
`default_nettype wire

// ----- design/kcrl_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
module kcrl_cell (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire [kcrl_pkg::IDX_W-1:0] idx,
	input  kcrl_pkg::req_t         req,
	input  kcrl_pkg::wr_t          wr,
	input  kcrl_pkg::link_t        link_in,
	output kcrl_pkg::link_t        link_out
);
	import kcrl_pkg::*;

	logic                valid_q;
	logic [KEY_BITS-1:0] key_q;
	logic [63:0]         stamp_q;
	link_t               link_q;
	logic                match;
	logic                lim_c;
	logic                sel;
	logic [63:0]         elapsed;

	assign elapsed = req.now - stamp_q;
	assign lim_c   = (req.now >= stamp_q) && (elapsed < {32'd0, req.cool});
	assign match   = link_in.active && !link_in.hit && valid_q && (key_q == req.key);
	assign sel     = wr.ins && (wr.slot == idx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			link_q  <= '0;
		end else begin
			if (sel) begin
				valid_q <= 1'b1;
			end
			link_q.active <= link_in.active;
			link_q.hit    <= link_in.hit | match;
			link_q.lim    <= link_in.lim | (match & lim_c);
		end
	end

	always_ff @(posedge clk) begin
		if (sel) begin
			key_q   <= req.key;
			stamp_q <= req.now;
		end else if (match && !lim_c) begin
			stamp_q <= req.now;
		end
	end

	assign link_out = link_q;

endmodule
`default_nettype wire

// ----- design/kcrl_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module kcrl_ctrl (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              req_valid,
	output logic             req_ready,
	input  wire              bypass,
	input  kcrl_pkg::link_t  tail,
	output logic             start,
	output kcrl_pkg::wr_t    wr,
	output logic             rsp_valid,
	input  wire              rsp_ready,
	output kcrl_pkg::out_t   rsp
);
	import kcrl_pkg::*;

	state_t           state_q, state_d;
	logic [IDX_W-1:0] victim_q;
	outcome_t         res_q;
	logic             rsp_valid_q;
	out_t             rsp_q;
	logic             accept;
	logic             load;
	logic             tail_done;

	assign accept    = req_valid && req_ready;
	assign tail_done = (state_q == ST_SEARCH) && tail.active;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_d = bypass ? ST_FINISH : ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (tail.active) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!rsp_valid_q || rsp_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req_ready = 1'b0;
		start     = 1'b0;
		load      = 1'b0;
		wr.ins    = 1'b0;
		wr.slot   = victim_q;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				start     = req_valid && !bypass;
			end
			ST_SEARCH: begin
				wr.ins = tail.active && !tail.hit;
			end
			ST_FINISH: begin
				load = !rsp_valid_q || rsp_ready;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			victim_q    <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (wr.ins) begin
				victim_q <= (victim_q == IDX_W'(ENTRIES - 1)) ? '0 : victim_q + 1'b1;
			end
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= OUT_BYPASS;
		end else if (tail_done) begin
			if (!tail.hit) begin
				res_q <= OUT_INSERTED;
			end else if (tail.lim) begin
				res_q <= OUT_LIMITED;
			end else begin
				res_q <= OUT_REFRESHED;
			end
		end
		if (load) begin
			rsp_q.limited <= (res_q == OUT_LIMITED);
			rsp_q.outcome <= res_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
`default_nettype wire

// ----- design/keyed_cooldown_rate_limiter.sv -----
// a bypass item goes from accept through ST_FINISH into the result register; any
// other item first sends the search token through chain[0] and every table cell,
// then ST_FINISH; one item at a time, the token walking one table cell per cycle
// the result register lets the next item be accepted while a result waits
// reset: arst_n async active low; clears all entry valid bits, the victim pointer and control
`timescale 1ns / 1ps
`default_nettype none
module keyed_cooldown_rate_limiter (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             req_valid,
	output logic            req_ready,
	input  kcrl_pkg::in_t   req,
	output logic            rsp_valid,
	input  wire             rsp_ready,
	output kcrl_pkg::out_t  rsp
);
	import kcrl_pkg::*;

	req_t  req_q;
	link_t chain [ENTRIES+1];
	wr_t   wr;
	logic  start;
	logic  bypass;

	assign bypass = !req.key_present || (req.cooldown == 32'd0);

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_q.key  <= req.key_tag[KEY_BITS-1:0];
			req_q.cool <= req.cooldown;
			req_q.now  <= req.now_time;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain[0] <= '0;
		end else begin
			chain[0].active <= start;
			chain[0].hit    <= 1'b0;
			chain[0].lim    <= 1'b0;
		end
	end

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		kcrl_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.idx      (IDX_W'(i)),
			.req      (req_q),
			.wr       (wr),
			.link_in  (chain[i]),
			.link_out (chain[i+1])
		);
	end

	kcrl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.bypass    (bypass),
		.tail      (chain[ENTRIES]),
		.start     (start),
		.wr        (wr),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule
`default_nettype wire

// ----- design/kcrl_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
module kcrl_checker (
	input wire             clk,
	input wire             arst_n,
	input wire             req_valid,
	input wire             req_ready,
	input kcrl_pkg::in_t   req,
	input wire             rsp_valid,
	input wire             rsp_ready,
	input kcrl_pkg::out_t  rsp
);
	import kcrl_pkg::*;

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
	else $error("result dropped or changed while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.limited == (rsp.outcome == OUT_LIMITED))
	else $error("limited flag disagrees with outcome");

	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
	else $error("second item taken while one is in work");

	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req.key_present && (req.cooldown != 32'd0)
		|=> !req_ready ##1 !req_ready)
	else $error("table search ended too early");

endmodule

bind keyed_cooldown_rate_limiter kcrl_checker u_kcrl_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);
`default_nettype wire

// ----- tb/sv/keyed_cooldown_rate_limiter_tb.sv -----
`timescale 1ns / 1ps
module keyed_cooldown_rate_limiter_tb;
	import kcrl_pkg::*;

	localparam int KEY_POOL = 40;
	localparam int IDLE_LIMIT = 3000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	in_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	out_t rsp;

	keyed_cooldown_rate_limiter u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always #6 clk = ~clk;

	// shadow copy of the key table
	logic                tbl_valid [ENTRIES];
	logic [KEY_BITS-1:0] tbl_key [ENTRIES];
	logic [63:0]         tbl_stamp [ENTRIES];
	int unsigned         victim;

	out_t pending_verdicts[$];
	int mismatches = 0;
	int idle_cycles = 0;
	int tx_gap_pct = 20;
	int rx_stall_pct = 20;
	int rx_hold = 0;
	int pool_span = 8;
	logic [63:0] key_pool [KEY_POOL];
	logic [63:0] clock_ms = 64'd1000;

	function automatic int pick_gap(input int pct);
		if ($urandom_range(99) >= pct)
			return 0;
		if ($urandom_range(9) == 0)
			return $urandom_range(20, 60);
		return $urandom_range(1, 3);
	endfunction

	function automatic out_t predict_verdict(input in_t x);
		out_t r;
		logic [KEY_BITS-1:0] k;
		int hit;
		k = x.key_tag[KEY_BITS-1:0];
		hit = -1;
		r.limited = 1'b0;
		r.outcome = OUT_BYPASS;
		if (!x.key_present || x.cooldown == 32'd0)
			return r;
		for (int i = 0; i < ENTRIES; i++) begin
			if (hit < 0 && tbl_valid[i] && tbl_key[i] == k)
				hit = i;
		end
		if (hit >= 0) begin
			if (x.now_time >= tbl_stamp[hit] &&
					(x.now_time - tbl_stamp[hit]) < {32'd0, x.cooldown}) begin
				r.limited = 1'b1;
				r.outcome = OUT_LIMITED;
			end else begin
				tbl_stamp[hit] = x.now_time;
				r.outcome = OUT_REFRESHED;
			end
		end else begin
			tbl_valid[victim] = 1'b1;
			tbl_key[victim] = k;
			tbl_stamp[victim] = x.now_time;
			victim = (victim + 1) % ENTRIES;
			r.outcome = OUT_INSERTED;
		end
		return r;
	endfunction

	function automatic in_t make_request(input logic [63:0] key, input logic present,
			input logic [31:0] cool, input logic [63:0] now);
		in_t x;
		x.key_tag = key;
		x.key_present = present;
		x.cooldown = cool;
		x.now_time = now;
		return x;
	endfunction

	function automatic in_t next_request();
		in_t x;
		int unsigned sel;
		x.key_tag = key_pool[$urandom_range(pool_span - 1)];
		if ($urandom_range(99) < 5)
			x.key_tag = {$urandom, $urandom};
		x.key_present = ($urandom_range(19) != 0);
		sel = $urandom_range(19);
		if (sel == 0)
			x.cooldown = 32'd0;
		else if (sel == 1)
			x.cooldown = $urandom;
		else
			x.cooldown = $urandom_range(1, 120);
		sel = $urandom_range(99);
		if (sel < 3)
			clock_ms = {$urandom, $urandom};
		else if (sel < 8)
			clock_ms = clock_ms - $urandom_range(1, 200);
		else
			clock_ms = clock_ms + $urandom_range(0, 30);
		x.now_time = clock_ms;
		return x;
	endfunction

	task automatic send_item(input in_t x);
		int gap;
		req <= x;
		req_valid <= 1'b1;
		do
			@(posedge clk);
		while (!req_ready);
		pending_verdicts.push_back(predict_verdict(x));
		gap = pick_gap(tx_gap_pct);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_bypass_and_edges();
		send_item(make_request(64'd5, 1'b0, 32'd100, 64'd10));
		send_item(make_request(64'd5, 1'b1, 32'd0, 64'd10));
		// zero key is an ordinary key
		send_item(make_request(64'd0, 1'b1, 32'd50, 64'd100));
		send_item(make_request(64'd0, 1'b1, 32'd50, 64'd120));
		// elapsed equal to cooldown
		send_item(make_request(64'd0, 1'b1, 32'd50, 64'd150));
		// time went backwards
		send_item(make_request(64'd0, 1'b1, 32'd50, 64'd10));
		send_item(make_request(64'd0, 1'b1, 32'hFFFF_FFFF, 64'd0));
		send_item(make_request(64'd0, 1'b1, 32'hFFFF_FFFF, 64'd5));
		send_item(make_request({64{1'b1}}, 1'b1, 32'hFFFF_FFFF, {64{1'b1}}));
		send_item(make_request({64{1'b1}}, 1'b1, 32'd1, {64{1'b1}}));
		send_item(make_request({64{1'b1}}, 1'b1, 32'd1, 64'd0));
		send_item(make_request({64{1'b1}}, 1'b0, 32'hFFFF_FFFF, {64{1'b1}}));
		send_item(make_request(64'h8000_0000_0000_0000, 1'b1, 32'h8000_0000, 64'd7));
		send_item(make_request(64'h8000_0000_0000_0000, 1'b1, 32'h8000_0000,
			64'd7 + 64'h7FFF_FFFF));
		wait_drained();
	endtask

	task automatic test_table_wrap();
		// fill past capacity, then the oldest key must come back as a new entry
		for (int i = 0; i <= ENTRIES; i++)
			send_item(make_request(64'h100 + i, 1'b1, 32'd1000, 64'd5000));
		send_item(make_request(64'h100, 1'b1, 32'd1000, 64'd5001));
		send_item(make_request(64'h100 + ENTRIES, 1'b1, 32'd1000, 64'd5002));
		wait_drained();
	endtask

	task automatic test_output_stall();
		tx_gap_pct = 0;
		pool_span = 6;
		rx_hold = 400;
		for (int i = 0; i < 12; i++)
			send_item(next_request());
		wait_drained();
	endtask

	task automatic test_random_traffic();
		for (int seg = 0; seg < 9; seg++) begin
			tx_gap_pct = (seg % 3 == 0) ? 0 : $urandom_range(10, 60);
			rx_stall_pct = (seg % 4 == 1) ? 0 : $urandom_range(10, 60);
			pool_span = (seg % 2 == 0) ? $urandom_range(3, 10) : $urandom_range(17, KEY_POOL);
			for (int i = 0; i < 200; i++)
				send_item(next_request());
		end
		wait_drained();
	endtask

	initial begin
		for (int i = 0; i < ENTRIES; i++) begin
			tbl_valid[i] = 1'b0;
			tbl_key[i] = '0;
			tbl_stamp[i] = '0;
		end
		victim = 0;
		for (int i = 0; i < KEY_POOL; i++)
			key_pool[i] = {$urandom, $urandom};
		key_pool[0] = 64'd0;
		key_pool[1] = {64{1'b1}};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_bypass_and_edges();
		test_table_wrap();
		test_output_stall();
		test_random_traffic();
		wait_drained();
		repeat (24) @(posedge clk);
		if (mismatches == 0 && pending_verdicts.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// receiver side
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rx_hold > 0) begin
				n = rx_hold;
				rx_hold = 0;
				rsp_ready <= 1'b0;
				repeat (n) @(posedge clk);
				rsp_ready <= 1'b1;
			end else begin
				n = pick_gap(rx_stall_pct);
				if (n == 0) begin
					rsp_ready <= 1'b1;
				end else begin
					rsp_ready <= 1'b0;
					repeat (n) @(posedge clk);
					rsp_ready <= 1'b1;
				end
			end
		end
	end

	always @(posedge clk) begin
		out_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_verdicts.size() == 0) begin
				$error("result with no item pending");
				mismatches++;
			end else begin
				want = pending_verdicts.pop_front();
				if (rsp.limited !== want.limited) begin
					$error("limited: expected %0d, actual %0d", want.limited, rsp.limited);
					mismatches++;
				end
				if (rsp.outcome !== want.outcome) begin
					$error("outcome: expected %0d, actual %0d", want.outcome, rsp.outcome);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

endmodule
